/* rtl/sha1s_pkg.sv */
// Shared types, constants and helpers for the SHA-1 stream hasher.
package sha1s_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned NUM_WORDS = 5;
    localparam int unsigned BLK_BYTES = 64;
    localparam int unsigned BLK_W     = BLK_BYTES * 8;
    localparam int unsigned ROUNDS    = 80;
    localparam int unsigned ROUND_W   = 7;
    localparam int unsigned CNT_W     = 61;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned LEN_W     = 64;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0]         PAD_BYTE  = 8'h80;
    localparam logic [POS_W-1:0]   LEN_POS   = 6'd56;
    localparam logic [POS_W-1:0]   LAST_POS  = 6'd63;
    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [IDX_W-1:0]   LAST_IDX  = 3'd4;

    localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_work;

    typedef struct packed {
        t_word            word;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_digest;

    function automatic t_word init_chain(input logic [IDX_W-1:0] idx);
        t_word h;
        case (idx)
            3'd0:    h = 32'h67452301;
            3'd1:    h = 32'hEFCDAB89;
            3'd2:    h = 32'h98BADCFE;
            3'd3:    h = 32'h10325476;
            default: h = 32'hC3D2E1F0;
        endcase
        return h;
    endfunction

endpackage

/* rtl/sha1_stream_hasher_top.sv */
// SHA-1 over a byte stream: one round per cycle in a shared round unit, five-word digest out.
// Absorb transfer: one byte; every 64th byte then holds input for 80 rounds and a fold step.
// Finish transfer: pad bytes go in one per cycle up to the block end, then each padded block
// (one or two) runs its rounds and fold; then five digest transfers at up to one per cycle.
// Sustained absorb rate is set by the round unit: input is held off while a block is hashed.
// Synchronous active-low reset restores the initial chaining words and clears the byte count.
module sha1_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        o_m_axis_tlast    // last_word
);

    logic               dig_valid;
    logic               dig_ready;
    sha1s_pkg::t_digest dig;

    logic               r_out_valid;
    sha1s_pkg::t_digest r_out;

    sha1s_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_opcode    (i_s_axis_tuser),
        .i_byte      (i_s_axis_tdata),
        .o_dig_valid (dig_valid),
        .i_dig_ready (dig_ready),
        .o_dig       (dig)
    );

    // refill the output register when empty or being drained
    assign dig_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (dig_valid && dig_ready) begin
                r_out_valid <= 1'b1;
                r_out       <= dig;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b00000, r_out.idx, r_out.word};
    assign o_m_axis_tlast  = r_out.last;

endmodule

/* rtl/sha1s_round.sv */
// One SHA-1 round and one message schedule step, shared by all 80 rounds.
module sha1s_round (
    input  logic [sha1s_pkg::ROUND_W-1:0] i_round,
    input  sha1s_pkg::t_work              i_work,
    input  sha1s_pkg::t_word              i_w0,
    input  sha1s_pkg::t_word              i_w2,
    input  sha1s_pkg::t_word              i_w8,
    input  sha1s_pkg::t_word              i_w13,
    output sha1s_pkg::t_work              o_work,
    output sha1s_pkg::t_word              o_w_new
);

    sha1s_pkg::t_word f;
    sha1s_pkg::t_word k;
    sha1s_pkg::t_word t;
    sha1s_pkg::t_word x;

    always_comb begin
        if (i_round inside {[7'd0:7'd19]}) begin
            f = i_work.d ^ (i_work.b & (i_work.c ^ i_work.d));
            k = sha1s_pkg::K_0;
        end else if (i_round inside {[7'd20:7'd39]}) begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = sha1s_pkg::K_1;
        end else if (i_round inside {[7'd40:7'd59]}) begin
            f = (i_work.b & i_work.c) | (i_work.d & (i_work.b | i_work.c));
            k = sha1s_pkg::K_2;
        end else begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = sha1s_pkg::K_3;
        end
    end

    assign t = {i_work.a[26:0], i_work.a[31:27]} + f + i_work.e + k + i_w0;

    assign o_work.a = t;
    assign o_work.b = i_work.a;
    assign o_work.c = {i_work.b[1:0], i_work.b[31:2]};
    assign o_work.d = i_work.c;
    assign o_work.e = i_work.d;

    // W[t+16] from the sliding 16-word window
    assign x       = i_w13 ^ i_w8 ^ i_w2 ^ i_w0;
    assign o_w_new = {x[30:0], x[31]};

endmodule

/* rtl/sha1s_core.sv */
// Sequencer, block window, chaining words and byte count of the SHA-1 hasher.
module sha1s_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_opcode,
    input  logic [7:0]            i_byte,
    output logic                  o_dig_valid,
    input  logic                  i_dig_ready,
    output sha1s_pkg::t_digest    o_dig
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [sha1s_pkg::BLK_W-1:0]   r_blk;
    sha1s_pkg::t_work              r_work;
    sha1s_pkg::t_word              r_chain [sha1s_pkg::NUM_WORDS];
    logic [sha1s_pkg::CNT_W-1:0]   r_count;
    logic [sha1s_pkg::POS_W-1:0]   r_pos;
    logic [sha1s_pkg::LEN_W-1:0]   r_len;
    logic [sha1s_pkg::ROUND_W-1:0] r_round;
    logic [sha1s_pkg::IDX_W-1:0]   r_idx;
    logic                          r_fin;
    logic                          r_extra;
    logic                          r_first;

    sha1s_pkg::t_work rnd_work;
    sha1s_pkg::t_word rnd_w_new;
    logic [7:0]       pad_byte;
    logic             accept;
    logic             emit_take;
    logic             len_byte;

    sha1s_round u_round (
        .i_round (r_round),
        .i_work  (r_work),
        .i_w0    (r_blk[511:480]),
        .i_w2    (r_blk[447:416]),
        .i_w8    (r_blk[255:224]),
        .i_w13   (r_blk[95:64]),
        .o_work  (rnd_work),
        .o_w_new (rnd_w_new)
    );

    assign o_ready     = (r_state == ST_IDLE);
    assign accept      = i_valid && o_ready;
    assign o_dig_valid = (r_state == ST_EMIT);
    assign emit_take   = o_dig_valid && i_dig_ready;

    assign o_dig.word = r_chain[r_idx];
    assign o_dig.idx  = r_idx;
    assign o_dig.last = (r_idx == sha1s_pkg::LAST_IDX);

    // length bytes go only into the final padded block
    assign len_byte = (r_pos >= sha1s_pkg::LEN_POS) && !r_extra && !r_first;
    assign pad_byte = r_first  ? sha1s_pkg::PAD_BYTE :
                      len_byte ? r_len[63:56] : 8'h00;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == sha1s_pkg::OP_FINISH) begin
                        n_state = ST_PAD;
                    end else if (r_count[5:0] == sha1s_pkg::LAST_POS) begin
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_PAD: begin
                if (r_pos == sha1s_pkg::LAST_POS) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_round == sha1s_pkg::LAST_ROUND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (r_fin && r_extra) begin
                    n_state = ST_PAD;
                end else if (r_fin) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (emit_take && o_dig.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_round <= '0;
            r_idx   <= '0;
            r_fin   <= 1'b0;
            r_extra <= 1'b0;
            r_first <= 1'b0;
            r_pos   <= '0;
            for (int i = 0; i < sha1s_pkg::NUM_WORDS; i++) begin
                r_chain[i] <= sha1s_pkg::init_chain(sha1s_pkg::IDX_W'(i));
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_round <= '0;
                    r_work  <= {r_chain[0], r_chain[1], r_chain[2], r_chain[3], r_chain[4]};
                    if (accept) begin
                        if (i_opcode == sha1s_pkg::OP_FINISH) begin
                            r_fin   <= 1'b1;
                            r_first <= 1'b1;
                            r_pos   <= r_count[5:0];
                            r_extra <= (r_count[5:0] >= sha1s_pkg::LEN_POS);
                            r_len   <= {r_count, 3'b000};
                        end else begin
                            r_blk   <= {r_blk[sha1s_pkg::BLK_W-9:0], i_byte};
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                ST_PAD: begin
                    r_blk   <= {r_blk[sha1s_pkg::BLK_W-9:0], pad_byte};
                    r_first <= 1'b0;
                    r_pos   <= r_pos + 1'b1;
                    r_round <= '0;
                    r_work  <= {r_chain[0], r_chain[1], r_chain[2], r_chain[3], r_chain[4]};
                    if (len_byte) begin
                        r_len <= {r_len[sha1s_pkg::LEN_W-9:0], 8'h00};
                    end
                end
                ST_ROUND: begin
                    r_work  <= rnd_work;
                    r_blk   <= {r_blk[sha1s_pkg::BLK_W-33:0], rnd_w_new};
                    r_round <= r_round + 1'b1;
                end
                ST_FOLD: begin
                    r_chain[0] <= r_chain[0] + r_work.a;
                    r_chain[1] <= r_chain[1] + r_work.b;
                    r_chain[2] <= r_chain[2] + r_work.c;
                    r_chain[3] <= r_chain[3] + r_work.d;
                    r_chain[4] <= r_chain[4] + r_work.e;
                    r_extra    <= 1'b0;
                    r_idx      <= '0;
                end
                ST_EMIT: begin
                    if (emit_take) begin
                        r_idx <= r_idx + 1'b1;
                        if (o_dig.last) begin
                            // digest out: back to the initial chaining values
                            r_fin   <= 1'b0;
                            r_count <= '0;
                            for (int i = 0; i < sha1s_pkg::NUM_WORDS; i++) begin
                                r_chain[i] <= sha1s_pkg::init_chain(sha1s_pkg::IDX_W'(i));
                            end
                        end
                    end
                end
                default: begin
                    r_fin <= 1'b0;
                end
            endcase
        end
    end

endmodule
